### hdl/apqar_pkg.sv
// ----------------------------------------------------------------------------
// apqar_pkg
// Shared constants for the associative page store with age replacement.
// ----------------------------------------------------------------------------
package apqar_pkg;

	localparam int ENTRIES_DEFAULT = 8;
	localparam int PAGE_W          = 52;

	// action codes
	localparam logic ACT_INSERT = 1'b0;
	localparam logic ACT_LOOKUP = 1'b1;

endpackage

### hdl/apqar_match.sv
// ----------------------------------------------------------------------------
// apqar_match
// Parallel tag compare over all entries; picks the lowest valid match.
// ----------------------------------------------------------------------------
module apqar_match #(
	parameter int ENTRIES = apqar_pkg::ENTRIES_DEFAULT
) (
	input  logic [apqar_pkg::PAGE_W-1:0]              page,
	input  logic [ENTRIES-1:0][apqar_pkg::PAGE_W-1:0] pages,
	input  logic [ENTRIES-1:0]                        valid,
	output logic [ENTRIES-1:0]                        match_oh,
	output logic                                      hit
);

	logic [ENTRIES-1:0] match_vec;

	always_comb begin
		for (int i = 0; i < ENTRIES; i++) begin
			match_vec[i] = valid[i] && (pages[i] == page);
		end
	end

	// isolate lowest set bit
	assign match_oh = match_vec & (~match_vec + ENTRIES'(1));
	assign hit      = |match_vec;

endmodule

### hdl/apqar_age_ctl.sv
// ----------------------------------------------------------------------------
// apqar_age_ctl
// Next valid bits and ages for one beat, plus the entry to write on an insert miss.
// ----------------------------------------------------------------------------
module apqar_age_ctl #(
	parameter int ENTRIES = apqar_pkg::ENTRIES_DEFAULT,
	localparam int AGE_W  = $clog2(ENTRIES)
) (
	input  logic                           insert,
	input  logic                           hit,
	input  logic [ENTRIES-1:0]             match_oh,
	input  logic [ENTRIES-1:0]             valid,
	input  logic [ENTRIES-1:0][AGE_W-1:0]  age,
	output logic [ENTRIES-1:0]             valid_nx,
	output logic [ENTRIES-1:0][AGE_W-1:0]  age_nx,
	output logic [ENTRIES-1:0]             wr_oh
);

	localparam logic [AGE_W-1:0] AGE_MAX = AGE_W'(ENTRIES - 1);

	logic [ENTRIES-1:0] free_vec;
	logic [ENTRIES-1:0] free_oh;
	logic [ENTRIES-1:0] old_vec;
	logic [ENTRIES-1:0] old_oh;
	logic [ENTRIES-1:0] victim_oh;
	logic [ENTRIES-1:0] fill_oh;
	logic [AGE_W-1:0]   match_age;
	logic               full;

	assign free_vec = ~valid;
	assign free_oh  = free_vec & (~free_vec + ENTRIES'(1));
	assign full     = &valid;

	always_comb begin
		for (int i = 0; i < ENTRIES; i++) begin
			old_vec[i] = (age[i] == AGE_MAX);
		end
	end

	assign old_oh    = old_vec & (~old_vec + ENTRIES'(1));
	// no oldest entry in a full store: fall back to entry 0
	assign victim_oh = (|old_vec) ? old_oh : ENTRIES'(1);
	assign fill_oh   = full ? victim_oh : free_oh;
	assign wr_oh     = (insert && !hit) ? fill_oh : '0;

	always_comb begin
		match_age = '0;
		for (int i = 0; i < ENTRIES; i++) begin
			match_age = match_age | (match_oh[i] ? age[i] : '0);
		end
	end

	always_comb begin
		valid_nx = valid;
		age_nx   = age;
		if (insert) begin
			for (int j = 0; j < ENTRIES; j++) begin
				if (hit) begin
					if (match_oh[j]) begin
						age_nx[j] = '0;
					end else if (valid[j] && (age[j] < match_age) && (age[j] != AGE_MAX)) begin
						age_nx[j] = age[j] + AGE_W'(1);
					end
				end else begin
					if (fill_oh[j]) begin
						valid_nx[j] = 1'b1;
						age_nx[j]   = '0;
					end else if (valid[j] && (age[j] != AGE_MAX)) begin
						age_nx[j] = age[j] + AGE_W'(1);
					end
				end
			end
		end
	end

endmodule

### hdl/assoc_page_queue_age_replace.sv
// ----------------------------------------------------------------------------
// assoc_page_queue_age_replace
// Fully associative page store with age-based replacement.
// ----------------------------------------------------------------------------
// The request is registered in the s1 stage, then the result in done_q/hit_q.
// Throughput: one beat per cycle; busy stays low, the store updates in the
//   cycle after accept, so each beat sees all earlier beats' effects.
// Reset: arst_n clears all valid bits, ages and strobes at once.
// Results cannot be stalled: done is high for exactly one cycle per beat.
module assoc_page_queue_age_replace #(
	parameter int ENTRIES = apqar_pkg::ENTRIES_DEFAULT
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic                         action,
	input  logic [apqar_pkg::PAGE_W-1:0] page_number,
	output logic                         done,
	output logic                         hit
);

	localparam int AGE_W = $clog2(ENTRIES);

	logic                                      valid_s1;
	logic                                      action_s1;
	logic [apqar_pkg::PAGE_W-1:0]              page_s1;

	logic [ENTRIES-1:0]                        valid_q;
	logic [ENTRIES-1:0][AGE_W-1:0]             age_q;
	logic [ENTRIES-1:0][apqar_pkg::PAGE_W-1:0] page_q;

	logic                                      done_q;
	logic                                      hit_q;

	logic [ENTRIES-1:0]                        match_oh;
	logic                                      match_hit;
	logic                                      insert;
	logic [ENTRIES-1:0]                        valid_nx;
	logic [ENTRIES-1:0][AGE_W-1:0]             age_nx;
	logic [ENTRIES-1:0]                        wr_oh;

	assign busy   = 1'b0;
	assign insert = valid_s1 && (action_s1 == apqar_pkg::ACT_INSERT);

	apqar_match #(.ENTRIES(ENTRIES)) u_match (
		.page     (page_s1),
		.pages    (page_q),
		.valid    (valid_q),
		.match_oh (match_oh),
		.hit      (match_hit)
	);

	apqar_age_ctl #(.ENTRIES(ENTRIES)) u_age (
		.insert   (insert),
		.hit      (match_hit),
		.match_oh (match_oh),
		.valid    (valid_q),
		.age      (age_q),
		.valid_nx (valid_nx),
		.age_nx   (age_nx),
		.wr_oh    (wr_oh)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_q  <= '0;
			age_q    <= '0;
			done_q   <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
			valid_q  <= valid_nx;
			age_q    <= age_nx;
			done_q   <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			action_s1 <= action;
			page_s1   <= page_number;
		end
		hit_q <= match_hit;
		for (int i = 0; i < ENTRIES; i++) begin
			if (wr_oh[i]) begin
				page_q[i] <= page_s1;
			end
		end
	end

	assign done = done_q;
	assign hit  = hit_q;

endmodule

### hdl/apqar_checker.sv
// ----------------------------------------------------------------------------
// apqar_checker
// Port-level checks for the page store, bound to the top level.
// ----------------------------------------------------------------------------
module apqar_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         start,
	input logic                         busy,
	input logic                         action,
	input logic [apqar_pkg::PAGE_W-1:0] page_number,
	input logic                         done,
	input logic                         hit
);

	logic acc;
	assign acc = start && !busy;

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		acc |=> ##1 done)
		else $error("no result two cycles after accept");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(acc, 2))
		else $error("result without matching accept");

	a_insert_then_hit: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && action == apqar_pkg::ACT_INSERT) ##1
		(acc && action == apqar_pkg::ACT_LOOKUP && page_number == $past(page_number))
		|=> ##1 hit)
		else $error("lookup right after insert of same page missed");

	a_lookup_stable: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && action == apqar_pkg::ACT_LOOKUP) ##1
		(acc && action == apqar_pkg::ACT_LOOKUP && page_number == $past(page_number))
		|=> ##1 (hit == $past(hit)))
		else $error("back-to-back lookups of same page disagree");

endmodule

bind assoc_page_queue_age_replace apqar_checker u_apqar_checker (.*);
